FILE: rtl/core/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiply unit.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int unsigned DIM       = 4;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ElemW     = 32;
  localparam int unsigned RowW      = $clog2(DIM);

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic [RowW-1:0]         row_t;

  typedef struct packed {
    elem_t a_elem0;
    elem_t a_elem1;
    elem_t a_elem2;
    elem_t a_elem3;
    elem_t b_elem0;
    elem_t b_elem1;
    elem_t b_elem2;
    elem_t b_elem3;
  } in_req_t;

  typedef struct packed {
    elem_t c_elem0;
    elem_t c_elem1;
    elem_t c_elem2;
    elem_t c_elem3;
    row_t  out_row;
    logic  last_row;
  } out_req_t;

  // tag that follows a product row down the lane pipeline
  typedef struct packed {
    logic vld;
    row_t row;
    logic last;
  } issue_t;

endpackage

FILE: rtl/core/matrix4x4_multiply_unit.sv
// ----------------------------------------------------------------------------
// matrix4x4_multiply_unit
// C = A x B for 4x4 signed Q16.16 matrices, one row pair per request in,
// one product row per request out, saturated to 32 bits.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid_i / in_ready_o   in_req_i  (row r of A and of B)
//  out      out_valid_o / out_ready_i out_req_o (product row, row index, last)
//
//  rows 0..3 are taken one per cycle; after row 3 the input stalls while the
//  four product rows are issued to the column lanes, and rows of the next
//  matrix pair are taken again once the last of them has been issued.
//  an issued product row reaches the output through the product, pair-sum and output registers.
//  reset returns the row counter to row 0 and drops all pending results.
//  out_ready_i low while a result is held freezes the lane pipeline and the
//  row issue; input rows 0..3 of the next matrix are still taken while results drain.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mm4_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mm4_pkg::out_req_t out_req_o
);

  mm4_pkg::issue_t   issue;
  mm4_pkg::issue_t   s1_q, s2_q;
  mm4_pkg::elem_t    a_row [mm4_pkg::DIM];
  mm4_pkg::elem_t    b_mat [mm4_pkg::DIM][mm4_pkg::DIM];
  mm4_pkg::elem_t    b_col [mm4_pkg::DIM][mm4_pkg::DIM];
  mm4_pkg::elem_t    dot   [mm4_pkg::DIM];
  mm4_pkg::out_req_t out_q, out_d;
  logic              out_valid_q;
  logic              adv;

  // whole pipeline moves when the output register is free or being drained
  assign adv = !out_valid_q || out_ready_i;

  mm4_row_buf u_row_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .adv_i      (adv),
    .issue_o    (issue),
    .a_row_o    (a_row),
    .b_mat_o    (b_mat)
  );

  always_comb begin
    for (int j = 0; j < mm4_pkg::DIM; j++) begin
      for (int k = 0; k < mm4_pkg::DIM; k++) begin
        b_col[j][k] = b_mat[k][j];
      end
    end
  end

  for (genvar j = 0; j < mm4_pkg::DIM; j++) begin : g_lane
    mm4_lane u_lane (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .a_row_i (a_row),
      .b_col_i (b_col[j]),
      .dot_o   (dot[j])
    );
  end

  // merge the lane results with the row tag
  always_comb begin
    out_d.c_elem0  = dot[0];
    out_d.c_elem1  = dot[1];
    out_d.c_elem2  = dot[2];
    out_d.c_elem3  = dot[3];
    out_d.out_row  = s2_q.row;
    out_d.last_row = s2_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_q        <= issue;
      s2_q        <= s1_q;
      out_valid_q <= s2_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_q.vld) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

FILE: rtl/core/mm4_row_buf.sv
// ----------------------------------------------------------------------------
// mm4_row_buf
// Row storage for both operand matrices, input row counter and the
// sequencer that issues the product rows to the lanes.
// ----------------------------------------------------------------------------
module mm4_row_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mm4_pkg::in_req_t  in_req_i,
  input  logic              adv_i,
  output mm4_pkg::issue_t   issue_o,
  output mm4_pkg::elem_t    a_row_o [mm4_pkg::DIM],
  output mm4_pkg::elem_t    b_mat_o [mm4_pkg::DIM][mm4_pkg::DIM]
);

  localparam mm4_pkg::row_t LastRow = mm4_pkg::RowW'(mm4_pkg::DIM - 1);

  mm4_pkg::elem_t a_q [mm4_pkg::DIM][mm4_pkg::DIM];
  mm4_pkg::elem_t b_q [mm4_pkg::DIM][mm4_pkg::DIM];
  mm4_pkg::elem_t a_in [mm4_pkg::DIM];
  mm4_pkg::elem_t b_in [mm4_pkg::DIM];

  mm4_pkg::row_t wr_row_q, wr_row_d;
  mm4_pkg::row_t iss_row_q, iss_row_d;
  logic          busy_q, busy_d;
  logic          accept;

  assign a_in[0] = in_req_i.a_elem0;
  assign a_in[1] = in_req_i.a_elem1;
  assign a_in[2] = in_req_i.a_elem2;
  assign a_in[3] = in_req_i.a_elem3;
  assign b_in[0] = in_req_i.b_elem0;
  assign b_in[1] = in_req_i.b_elem1;
  assign b_in[2] = in_req_i.b_elem2;
  assign b_in[3] = in_req_i.b_elem3;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && !busy_q;

  always_comb begin
    wr_row_d  = wr_row_q;
    iss_row_d = iss_row_q;
    busy_d    = busy_q;
    if (accept) begin
      wr_row_d = (wr_row_q == LastRow) ? '0 : wr_row_q + 1'b1;
      if (wr_row_q == LastRow) begin
        busy_d    = 1'b1;
        iss_row_d = '0;
      end
    end else if (busy_q && adv_i) begin
      iss_row_d = iss_row_q + 1'b1;
      if (iss_row_q == LastRow) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_row_q  <= '0;
      iss_row_q <= '0;
      busy_q    <= 1'b0;
    end else begin
      wr_row_q  <= wr_row_d;
      iss_row_q <= iss_row_d;
      busy_q    <= busy_d;
    end
  end

  // row storage, written only while no product rows are being issued
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int j = 0; j < mm4_pkg::DIM; j++) begin
        a_q[wr_row_q][j] <= a_in[j];
        b_q[wr_row_q][j] <= b_in[j];
      end
    end
  end

  always_comb begin
    issue_o.vld  = busy_q;
    issue_o.row  = iss_row_q;
    issue_o.last = (iss_row_q == LastRow);
    for (int j = 0; j < mm4_pkg::DIM; j++) begin
      a_row_o[j] = a_q[iss_row_q][j];
    end
    for (int k = 0; k < mm4_pkg::DIM; k++) begin
      for (int j = 0; j < mm4_pkg::DIM; j++) begin
        b_mat_o[k][j] = b_q[k][j];
      end
    end
  end

endmodule

FILE: rtl/core/mm4_lane.sv
// ----------------------------------------------------------------------------
// mm4_lane
// One column lane: four registered products, registered pair sums, then the
// final sum with floor shift and 32-bit saturation.
// ----------------------------------------------------------------------------
module mm4_lane (
  input  logic           clk_i,
  input  logic           adv_i,
  input  mm4_pkg::elem_t a_row_i [mm4_pkg::DIM],
  input  mm4_pkg::elem_t b_col_i [mm4_pkg::DIM],
  output mm4_pkg::elem_t dot_o
);

  localparam int unsigned ProdW  = 2 * mm4_pkg::ElemW;
  localparam int unsigned PairW  = ProdW + 1;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned NPairs = mm4_pkg::DIM / 2;

  localparam logic signed [SumW-1:0] SatMax =
    {{(SumW - mm4_pkg::ElemW + 1){1'b0}}, {(mm4_pkg::ElemW - 1){1'b1}}};
  localparam logic signed [SumW-1:0] SatMin =
    {{(SumW - mm4_pkg::ElemW + 1){1'b1}}, {(mm4_pkg::ElemW - 1){1'b0}}};

  logic signed [ProdW-1:0] prod_q [mm4_pkg::DIM];
  logic signed [PairW-1:0] pair_q [NPairs];
  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  shifted;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < mm4_pkg::DIM; k++) begin
        prod_q[k] <= a_row_i[k] * b_col_i[k];
      end
      for (int p = 0; p < NPairs; p++) begin
        pair_q[p] <= PairW'(prod_q[2*p]) + PairW'(prod_q[2*p+1]);
      end
    end
  end

  always_comb begin
    sum     = SumW'(pair_q[0]) + SumW'(pair_q[1]);
    shifted = sum >>> mm4_pkg::FRAC_BITS;
    if (shifted > SatMax) begin
      dot_o = mm4_pkg::elem_t'(SatMax);
    end else if (shifted < SatMin) begin
      dot_o = mm4_pkg::elem_t'(SatMin);
    end else begin
      dot_o = shifted[mm4_pkg::ElemW-1:0];
    end
  end

endmodule

FILE: rtl/core/mm4_checker.sv
// ----------------------------------------------------------------------------
// mm4_checker
// Port-level checks for the matrix multiply unit, bound to the top level.
// ----------------------------------------------------------------------------
module mm4_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input mm4_pkg::out_req_t out_req_o
);

  localparam mm4_pkg::row_t LastRow = mm4_pkg::RowW'(mm4_pkg::DIM - 1);

  mm4_pkg::row_t in_cnt_q;
  mm4_pkg::row_t out_cnt_q;
  logic          in_acc;
  logic          out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (in_acc) begin
        in_cnt_q <= in_cnt_q + 1'b1;
      end
      if (out_acc) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end
    end
  end

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // product rows come out in order
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.out_row == out_cnt_q)
    else $error("product row out of order");

  // last flag marks the final row only
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.last_row == (out_req_o.out_row == LastRow))
    else $error("last flag mismatch");

  // the final input row starts the issue phase, which blocks input
  a_issue_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_cnt_q == LastRow |=> !in_ready_o)
    else $error("input taken during row issue");

endmodule

bind matrix4x4_multiply_unit mm4_checker u_mm4_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_req_o   (out_req_o)
);
